// ===== rtl/idll_pkg.sv =====
// shared widths, command kinds and status codes of the linked list engine
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

  localparam int unsigned POOL_NODES_DEF = 1024;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;

  // stream beat widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_TAIL = 3'd0,
    KIND_PUSH_HEAD = 3'd1,
    KIND_INSERT    = 3'd2,
    KIND_POP_TAIL  = 3'd3,
    KIND_POP_HEAD  = 3'd4,
    KIND_ERASE     = 3'd5
  } kind_e;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/idll_nodes.sv =====
// node store: next, prev and value memories plus the head and tail sentinel links
`timescale 1ns / 1ps
`default_nettype none

module idll_nodes #(
  parameter int unsigned POOL_NODES = idll_pkg::POOL_NODES_DEF,
  localparam int unsigned SLOT_W = $clog2(POOL_NODES + 2),
  localparam int unsigned NODE_W = $clog2(POOL_NODES)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [SLOT_W-1:0]          rd_slot_i,
  input  wire logic                       next_we_i,
  input  wire logic [SLOT_W-1:0]          next_slot_i,
  input  wire logic [SLOT_W-1:0]          next_data_i,
  input  wire logic                       prev_we_i,
  input  wire logic [SLOT_W-1:0]          prev_slot_i,
  input  wire logic [SLOT_W-1:0]          prev_data_i,
  input  wire logic                       val_we_i,
  input  wire logic [NODE_W-1:0]          val_node_i,
  input  wire logic [idll_pkg::VAL_W-1:0] val_data_i,
  output logic      [SLOT_W-1:0]          next_rd_o,
  output logic      [SLOT_W-1:0]          prev_rd_o,
  output logic      [idll_pkg::VAL_W-1:0] val_rd_o,
  output logic      [SLOT_W-1:0]          head_next_o,
  output logic      [SLOT_W-1:0]          tail_prev_o
);
  import idll_pkg::*;

  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(POOL_NODES);
  localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(POOL_NODES + 1);
  localparam logic [SLOT_W-1:0] POOL_LIM  = SLOT_W'(POOL_NODES);

  logic [SLOT_W-1:0] next_mem [POOL_NODES];
  logic [SLOT_W-1:0] prev_mem [POOL_NODES];
  logic [VAL_W-1:0]  val_mem  [POOL_NODES];

  logic [SLOT_W-1:0] head_next_q, head_next_d;
  logic [SLOT_W-1:0] tail_prev_q, tail_prev_d;

  logic next_mem_we, prev_mem_we;

  // sentinel links live in flops so reset needs no memory sweep
  always_comb begin
    head_next_d = head_next_q;
    tail_prev_d = tail_prev_q;
    next_mem_we = 1'b0;
    prev_mem_we = 1'b0;
    if (next_we_i) begin
      if (next_slot_i == HEAD_SLOT) begin
        head_next_d = next_data_i;
      end else if (next_slot_i < POOL_LIM) begin
        next_mem_we = 1'b1;
      end
    end
    if (prev_we_i) begin
      if (prev_slot_i == TAIL_SLOT) begin
        tail_prev_d = prev_data_i;
      end else if (prev_slot_i < POOL_LIM) begin
        prev_mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_next_q <= TAIL_SLOT;
      tail_prev_q <= HEAD_SLOT;
    end else begin
      head_next_q <= head_next_d;
      tail_prev_q <= tail_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_mem_we) begin
      next_mem[next_slot_i[NODE_W-1:0]] <= next_data_i;
    end
    if (prev_mem_we) begin
      prev_mem[prev_slot_i[NODE_W-1:0]] <= prev_data_i;
    end
    if (val_we_i) begin
      val_mem[val_node_i] <= val_data_i;
    end
    next_rd_o <= next_mem[rd_slot_i[NODE_W-1:0]];
    prev_rd_o <= prev_mem[rd_slot_i[NODE_W-1:0]];
    val_rd_o  <= val_mem[rd_slot_i[NODE_W-1:0]];
  end

  assign head_next_o = head_next_q;
  assign tail_prev_o = tail_prev_q;

endmodule

`default_nettype wire

// ===== rtl/indexed_linked_list_engine.sv =====
// top level: command sequencer of the array based doubly linked list
// pushes and insert pass S_READ, S_LINK1, S_LINK2; pops and erase S_READ, S_UNLINK; all end in S_DONE
// insert and erase first walk the list, S_WALK_A and S_WALK_B per position (one link read per hop)
// one command at a time: s_axis_tready is high only in S_IDLE, which is reached when the result loads
// the result sits in an output register, so the next command is taken while it waits
// reset: sentinels linked to each other, counts cleared; node memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module indexed_linked_list_engine #(
  parameter int unsigned POOL_NODES = idll_pkg::POOL_NODES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // kind[2:0], position[13:3], value[45:14], zero[47:46]
  input  wire logic [idll_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // popped_value[31:0], status[33:32], zero[39:34]
  output logic      [idll_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import idll_pkg::*;

  localparam int unsigned SLOT_W = $clog2(POOL_NODES + 2);
  localparam int unsigned NODE_W = $clog2(POOL_NODES);
  localparam int unsigned CNT_W  = $clog2(POOL_NODES + 1);
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(POOL_NODES + 1);
  localparam logic [CNT_W-1:0]  POOL_FULL = CNT_W'(POOL_NODES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK_A = 3'd1;
  localparam logic [2:0] S_WALK_B = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_LINK1  = 3'd4;
  localparam logic [2:0] S_LINK2  = 3'd5;
  localparam logic [2:0] S_UNLINK = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]        state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [POS_W-1:0]  steps_q, steps_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] pred_q, pred_d;
  logic [CNT_W-1:0]  alloc_q, alloc_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [VAL_W-1:0]  popped_q, popped_d;
  logic              m_valid_q, m_valid_d;
  logic [STAT_W-1:0] m_status_q, m_status_d;
  logic [VAL_W-1:0]  m_popped_q, m_popped_d;

  logic [KIND_W-1:0] in_kind;
  logic [POS_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_val;
  logic [CMP_W-1:0]  pos_x, cnt_x;
  logic              pool_full, list_empty, in_beat;

  logic              next_we, prev_we, val_we;
  logic [SLOT_W-1:0] next_slot, next_data, prev_slot, prev_data;
  logic [SLOT_W-1:0] next_rd, prev_rd, head_next, tail_prev, fresh_slot, link_pred;
  logic [VAL_W-1:0]  val_rd;

  idll_nodes #(
    .POOL_NODES(POOL_NODES)
  ) u_nodes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_slot_i  (cur_q),
    .next_we_i  (next_we),
    .next_slot_i(next_slot),
    .next_data_i(next_data),
    .prev_we_i  (prev_we),
    .prev_slot_i(prev_slot),
    .prev_data_i(prev_data),
    .val_we_i   (val_we),
    .val_node_i (alloc_q[NODE_W-1:0]),
    .val_data_i (value_q),
    .next_rd_o  (next_rd),
    .prev_rd_o  (prev_rd),
    .val_rd_o   (val_rd),
    .head_next_o(head_next),
    .tail_prev_o(tail_prev)
  );

  assign in_kind    = s_axis_tdata[2:0];
  assign in_pos     = s_axis_tdata[13:3];
  assign in_val     = s_axis_tdata[45:14];
  assign pos_x      = CMP_W'(in_pos);
  assign cnt_x      = CMP_W'(count_q);
  assign pool_full  = (alloc_q == POOL_FULL);
  assign list_empty = (count_q == '0);
  assign fresh_slot = SLOT_W'(alloc_q);
  // the successor's predecessor; tail's lives in a flop
  assign link_pred  = (cur_q == TAIL_SLOT) ? tail_prev : prev_rd;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    steps_d    = steps_q;
    value_d    = value_q;
    cur_d      = cur_q;
    pred_d     = pred_q;
    alloc_d    = alloc_q;
    count_d    = count_q;
    status_d   = status_q;
    popped_d   = popped_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_popped_d = m_popped_q;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    val_we     = 1'b0;
    next_slot  = pred_q;
    next_data  = fresh_slot;
    prev_slot  = cur_q;
    prev_data  = fresh_slot;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          kind_d   = kind_e'(in_kind);
          steps_d  = in_pos;
          value_d  = in_val;
          status_d = ST_DONE;
          popped_d = '0;
          cur_d    = head_next;
          state_d  = S_DONE;
          case (kind_e'(in_kind))
            KIND_PUSH_TAIL: begin
              if (pool_full) begin
                status_d = ST_FULL;
              end else begin
                cur_d   = TAIL_SLOT;
                state_d = S_READ;
              end
            end
            KIND_PUSH_HEAD: begin
              if (pool_full) begin
                status_d = ST_FULL;
              end else begin
                state_d = S_READ;
              end
            end
            KIND_INSERT: begin
              if (pool_full) begin
                status_d = ST_FULL;
              end else if (pos_x > cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                state_d = (in_pos == '0) ? S_READ : S_WALK_A;
              end
            end
            KIND_POP_TAIL: begin
              if (list_empty) begin
                status_d = ST_RANGE;
              end else begin
                cur_d   = tail_prev;
                state_d = S_READ;
              end
            end
            KIND_POP_HEAD: begin
              if (list_empty) begin
                status_d = ST_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            KIND_ERASE: begin
              if (pos_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                state_d = (in_pos == '0) ? S_READ : S_WALK_A;
              end
            end
            default: begin
              status_d = ST_DONE;
            end
          endcase
        end
      end
      // read of next link at cur_q is under way
      S_WALK_A: begin
        state_d = S_WALK_B;
      end
      S_WALK_B: begin
        cur_d   = next_rd;
        steps_d = steps_q - POS_W'(1);
        state_d = (steps_q == POS_W'(1)) ? S_READ : S_WALK_A;
      end
      S_READ: begin
        if (kind_q == KIND_PUSH_TAIL || kind_q == KIND_PUSH_HEAD ||
            kind_q == KIND_INSERT) begin
          state_d = S_LINK1;
        end else begin
          state_d = S_UNLINK;
        end
      end
      // fresh node gets its value and both links
      S_LINK1: begin
        next_we   = 1'b1;
        next_slot = fresh_slot;
        next_data = cur_q;
        prev_we   = 1'b1;
        prev_slot = fresh_slot;
        prev_data = link_pred;
        val_we    = 1'b1;
        pred_d    = link_pred;
        state_d   = S_LINK2;
      end
      // neighbours point at the fresh node
      S_LINK2: begin
        next_we   = 1'b1;
        next_slot = pred_q;
        next_data = fresh_slot;
        prev_we   = 1'b1;
        prev_slot = cur_q;
        prev_data = fresh_slot;
        alloc_d   = alloc_q + CNT_W'(1);
        count_d   = count_q + CNT_W'(1);
        state_d   = S_DONE;
      end
      S_UNLINK: begin
        next_we   = 1'b1;
        next_slot = prev_rd;
        next_data = next_rd;
        prev_we   = 1'b1;
        prev_slot = next_rd;
        prev_data = prev_rd;
        count_d   = count_q - CNT_W'(1);
        popped_d  = (kind_q == KIND_ERASE) ? '0 : val_rd;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_popped_d = popped_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      alloc_q   <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      alloc_q   <= alloc_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    steps_q    <= steps_d;
    value_q    <= value_d;
    cur_q      <= cur_d;
    pred_q     <= pred_d;
    status_q   <= status_d;
    popped_q   <= popped_d;
    m_status_q <= m_status_d;
    m_popped_q <= m_popped_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - VAL_W - STAT_W){1'b0}}, m_status_q, m_popped_q};

endmodule

`default_nettype wire
